[src/lapped_pre_post_filter_4point_unit_defines.svh]
// ----------------------------------------------------------------------------
// lapped pre/post filter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef LAPPED_PRE_POST_FILTER_4POINT_UNIT_DEFINES_SVH
`define LAPPED_PRE_POST_FILTER_4POINT_UNIT_DEFINES_SVH

// same-cycle implication
`define LPPF_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lppf same-cycle check failed");

// next-cycle implication
`define LPPF_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lppf next-cycle check failed");

`endif

[src/lppf_pkg.sv]
// ----------------------------------------------------------------------------
// lppf_pkg
// constants, register codes and arithmetic helpers of the 4-point lapped filter
// ----------------------------------------------------------------------------
`default_nettype none

package lppf_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned RegW    = 16;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned QShift  = 6;
  localparam int unsigned NumStg  = 8;

  // configuration register codes
  typedef enum logic [RegIdxW-1:0] {
    REG_INVERSE_MODE = 3'd0,
    REG_SCALE_EVEN   = 3'd1,
    REG_SCALE_ODD    = 3'd2,
    REG_LIFT_PREDICT = 3'd3,
    REG_LIFT_UPDATE  = 3'd4,
    REG_RECIP_EVEN   = 3'd5,
    REG_RECIP_ODD    = 3'd6
  } reg_index_t;

  // one pipeline stage's working set
  typedef struct packed {
    logic [CoefW-1:0] mid;
    logic [CoefW-1:0] outer;
    logic [CoefW-1:0] prod;
    logic [CoefW-1:0] hi;
    logic [CoefW-1:0] lo;
  } stage_t;

  // arithmetic shift right, 32-bit
  function automatic logic [CoefW-1:0] asr(input logic [CoefW-1:0] v,
                                           input logic [2:0] n);
    return CoefW'($signed(v) >>> n);
  endfunction

  // 32 x 16 multiply keeping the low 32 bits
  function automatic logic [CoefW-1:0] mul_lo(input logic [CoefW-1:0] v,
                                              input logic signed [RegW-1:0] k);
    logic signed [CoefW+RegW-1:0] p;
    p = $signed(v) * k;
    return p[CoefW-1:0];
  endfunction

  // q6 scale: shift down, then bump positive results by one
  function automatic logic [CoefW-1:0] scale_q6(input logic [CoefW-1:0] p);
    logic [CoefW-1:0] s;
    s = asr(p, 3'(QShift));
    if ((s != '0) && !s[CoefW-1]) begin
      s = s + CoefW'(1);
    end
    return s;
  endfunction

  // q6 lift with rounding
  function automatic logic [CoefW-1:0] lift_q6(input logic [CoefW-1:0] p);
    logic [CoefW-1:0] t;
    t = p + CoefW'(1 << (QShift - 1));
    return asr(t, 3'(QShift));
  endfunction

endpackage

`default_nettype wire

[src/lppf_coef_if.sv]
// ----------------------------------------------------------------------------
// lppf_coef_if
// input channel: four signed coefficients with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface lppf_coef_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_d;

  modport source (output valid, coef_a, coef_b, coef_c, coef_d, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, coef_d, output ready);
endinterface

`default_nettype wire

[src/lppf_res_if.sv]
// ----------------------------------------------------------------------------
// lppf_res_if
// output channel: four filtered coefficients with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface lppf_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_a;
  logic signed [31:0] out_b;
  logic signed [31:0] out_c;
  logic signed [31:0] out_d;

  modport source (output valid, out_a, out_b, out_c, out_d, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface

`default_nettype wire

[src/lapped_pre_post_filter_4point_unit.sv]
// ----------------------------------------------------------------------------
// lapped_pre_post_filter_4point_unit
// 4-point lapped prefilter (forward) and postfilter (inverse), eight stages
// ----------------------------------------------------------------------------
// One word of four coefficients enters per cycle while the output is not
// stalled. The stages follow the chain of dependent multiplies: in forward
// mode, after an input butterfly stage, scale, predict lift and update lift
// each get a multiply stage followed by a shift/add stage, then a final
// butterfly stage that is also the output register; inverse mode undoes the
// update lift, then the predict lift, then applies the reciprocal multiplies.
// Every stage has its own valid bit and a stage only holds while the one
// after it is full and stalled, so bubbles are squeezed out and new words are
// taken while a result waits. Configuration registers are read live and must
// only be written while the pipeline is empty. All arithmetic wraps at 32 bits.
`default_nettype none

`include "lapped_pre_post_filter_4point_unit_defines.svh"

module lapped_pre_post_filter_4point_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lppf_pkg::RegIdxW-1:0] cfg_index,
  input  wire logic [lppf_pkg::RegW-1:0]    cfg_data,
  lppf_coef_if.sink                         coef,
  lppf_res_if.source                        res
);
  import lppf_pkg::*;

  // configuration registers
  logic                   inverse_mode;
  logic signed [RegW-1:0] scale_even;
  logic signed [RegW-1:0] scale_odd;
  logic signed [RegW-1:0] lift_predict;
  logic signed [RegW-1:0] lift_update;
  logic signed [RegW-1:0] recip_even;
  logic signed [RegW-1:0] recip_odd;

  // pipeline state
  logic   [NumStg-1:0] vld;
  logic   [NumStg:0]   rdy;
  stage_t              st      [NumStg];
  stage_t              st_next [NumStg];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
      scale_even   <= RegW'(64);
      scale_odd    <= RegW'(64);
      lift_predict <= '0;
      lift_update  <= '0;
      recip_even   <= RegW'(1);
      recip_odd    <= RegW'(1);
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_INVERSE_MODE: inverse_mode <= cfg_data[0];
        REG_SCALE_EVEN:   scale_even   <= cfg_data;
        REG_SCALE_ODD:    scale_odd    <= cfg_data;
        REG_LIFT_PREDICT: lift_predict <= cfg_data;
        REG_LIFT_UPDATE:  lift_update  <= cfg_data;
        REG_RECIP_EVEN:   recip_even   <= cfg_data;
        REG_RECIP_ODD:    recip_odd    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ready chain: a stage can load if empty or if the next one moves
  always_comb begin
    rdy[NumStg] = res.ready;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign coef.ready = rdy[0];

  // stage datapath
  always_comb begin
    // input butterflies
    st_next[0].mid   = coef.coef_b - coef.coef_c;
    st_next[0].outer = coef.coef_a - coef.coef_d;
    st_next[0].prod  = '0;
    st_next[0].hi    = coef.coef_b - asr(coef.coef_b - coef.coef_c, 3'd1);
    st_next[0].lo    = coef.coef_a - asr(coef.coef_a - coef.coef_d, 3'd1);

    for (int k = 1; k < NumStg; k++) begin
      st_next[k] = st[k-1];
    end

    // scale multiplies, or the update product of the inverse
    if (!inverse_mode) begin
      st_next[1].mid   = mul_lo(st[0].mid, scale_even);
      st_next[1].outer = mul_lo(st[0].outer, scale_odd);
    end else begin
      st_next[1].prod  = mul_lo(st[0].outer, lift_update);
    end

    // scale rounding, or undo the update lift
    if (!inverse_mode) begin
      st_next[2].mid   = scale_q6(st[1].mid);
      st_next[2].outer = scale_q6(st[1].outer);
    end else begin
      st_next[2].mid   = st[1].mid - lift_q6(st[1].prod);
    end

    // predict product
    st_next[3].prod = mul_lo(st[2].mid, lift_predict);

    // apply or undo the predict lift
    if (!inverse_mode) begin
      st_next[4].outer = st[3].outer + lift_q6(st[3].prod);
    end else begin
      st_next[4].outer = st[3].outer - lift_q6(st[3].prod);
    end

    // update product, or reciprocal multiplies of the inverse
    if (!inverse_mode) begin
      st_next[5].prod  = mul_lo(st[4].outer, lift_update);
    end else begin
      st_next[5].mid   = mul_lo(st[4].mid << QShift, recip_even);
      st_next[5].outer = mul_lo(st[4].outer << QShift, recip_odd);
    end

    // apply the update lift
    if (!inverse_mode) begin
      st_next[6].mid = st[5].mid + lift_q6(st[5].prod);
    end

    // output butterflies: lo, hi, then the differences in mid and outer
    st_next[7].lo    = st[6].lo + asr(st[6].outer, 3'd1);
    st_next[7].hi    = st[6].hi + asr(st[6].mid, 3'd1);
    st_next[7].mid   = st[6].hi + asr(st[6].mid, 3'd1) - st[6].mid;
    st_next[7].outer = st[6].lo + asr(st[6].outer, 3'd1) - st[6].outer;
  end

  // stage registers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= coef.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumStg; k++) begin
      if (rdy[k]) begin
        st[k] <= st_next[k];
      end
    end
  end

  // result word
  assign res.valid = vld[NumStg-1];
  assign res.out_a = st[NumStg-1].lo;
  assign res.out_b = st[NumStg-1].hi;
  assign res.out_c = st[NumStg-1].mid;
  assign res.out_d = st[NumStg-1].outer;

  // checks
  `LPPF_ASSERT_NXT(a_accept_fills_first, coef.valid && coef.ready, vld[0])
  `LPPF_ASSERT_NXT(a_stall_holds_tail, vld[NumStg-2] && !rdy[NumStg-1], vld[NumStg-2])
  `LPPF_ASSERT_IMP(a_full_pipe_blocks, (&vld) && !res.ready, !coef.ready)
  `LPPF_ASSERT_IMP(a_reset_config, $past(rst), !inverse_mode && (scale_even == RegW'(64)))

endmodule

`default_nettype wire

[dv/lapped_pre_post_filter_4point_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapped_pre_post_filter_4point_unit_tb
// Checks the 4-point lapped prefilter/postfilter against a local predictor.
// Words of four coefficients go in through a queue-fed driver. A monitor
// predicts each accepted word and compares every result field in order.
// The run covers several register settings in both modes, with and without
// idle cycles on either side.
// ----------------------------------------------------------------------------

module lapped_pre_post_filter_4point_unit_tb;
  import lppf_pkg::*;

  localparam logic [RegIdxW-1:0] REG_SPARE_IDX = 3'd7;
  localparam int unsigned        NumPhases     = 12;
  localparam int unsigned        DirectedWords = 8;
  localparam int unsigned        RandomWords   = 80;
  localparam int unsigned        StallLimit    = 4000;
  localparam int unsigned        DrainCycles   = 16;

  typedef struct {
    logic [CoefW-1:0] coef_a;
    logic [CoefW-1:0] coef_b;
    logic [CoefW-1:0] coef_c;
    logic [CoefW-1:0] coef_d;
  } coef_word_t;

  typedef struct {
    logic [CoefW-1:0] out_a;
    logic [CoefW-1:0] out_b;
    logic [CoefW-1:0] out_c;
    logic [CoefW-1:0] out_d;
  } filt_word_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [RegIdxW-1:0] cfg_index;
  logic [RegW-1:0]   cfg_data;

  lppf_coef_if coef_bus ();
  lppf_res_if  res_bus ();

  lapped_pre_post_filter_4point_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef_bus),
    .res       (res_bus)
  );

  // local copy of the register file
  logic                   inv_mode;
  logic signed [RegW-1:0] k_scale_even;
  logic signed [RegW-1:0] k_scale_odd;
  logic signed [RegW-1:0] k_lift_predict;
  logic signed [RegW-1:0] k_lift_update;
  logic signed [RegW-1:0] k_recip_even;
  logic signed [RegW-1:0] k_recip_odd;

  coef_word_t  words_to_send[$];
  filt_word_t  filtered_due[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // ---------------------------------------------------------------------------
  // filter arithmetic, all wrapping at 32 bits
  // ---------------------------------------------------------------------------
  function automatic logic [CoefW-1:0] sra32(input logic [CoefW-1:0] v, input int n);
    logic signed [CoefW-1:0] vs;
    vs = v;
    return vs >>> n;
  endfunction

  function automatic logic [CoefW-1:0] mul_low(input logic [CoefW-1:0] v,
                                               input logic signed [RegW-1:0] k);
    logic [CoefW-1:0] kx;
    kx = {{(CoefW-RegW){k[RegW-1]}}, k};
    return v * kx;
  endfunction

  function automatic logic [CoefW-1:0] q6_scale(input logic [CoefW-1:0] p);
    logic [CoefW-1:0] s;
    s = sra32(p, QShift);
    if (s != '0 && !s[CoefW-1]) begin
      s = s + 1;
    end
    return s;
  endfunction

  function automatic logic [CoefW-1:0] q6_lift(input logic [CoefW-1:0] p);
    return sra32(p + (1 << (QShift - 1)), QShift);
  endfunction

  function automatic filt_word_t lapped_filter(input coef_word_t w);
    logic [CoefW-1:0] outer;
    logic [CoefW-1:0] mid;
    logic [CoefW-1:0] hi;
    logic [CoefW-1:0] lo;
    filt_word_t       r;
    outer = w.coef_a - w.coef_d;
    mid   = w.coef_b - w.coef_c;
    hi    = w.coef_b - sra32(mid, 1);
    lo    = w.coef_a - sra32(outer, 1);
    if (!inv_mode) begin
      // prefilter: scale, then predict and update lifts
      mid   = q6_scale(mul_low(mid, k_scale_even));
      outer = q6_scale(mul_low(outer, k_scale_odd));
      outer = outer + q6_lift(mul_low(mid, k_lift_predict));
      mid   = mid + q6_lift(mul_low(outer, k_lift_update));
    end else begin
      // postfilter: undo lifts in reverse, then reciprocal multiply
      mid   = mid - q6_lift(mul_low(outer, k_lift_update));
      outer = outer - q6_lift(mul_low(mid, k_lift_predict));
      outer = mul_low(outer << QShift, k_recip_odd);
      mid   = mul_low(mid << QShift, k_recip_even);
    end
    lo      = lo + sra32(outer, 1);
    hi      = hi + sra32(mid, 1);
    r.out_a = lo;
    r.out_b = hi;
    r.out_c = hi - mid;
    r.out_d = lo - outer;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus values
  // ---------------------------------------------------------------------------
  function automatic logic [CoefW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom;
      3:       return CoefW'($urandom_range(0, 2000)) - 1000;
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          return 32'h7fff_ffff - $urandom_range(0, 255);
        end
        return 32'h8000_0000 + $urandom_range(0, 255);
      end
    endcase
  endfunction

  function automatic coef_word_t rand_word();
    coef_word_t w;
    w.coef_a = rand_coef();
    w.coef_b = rand_coef();
    w.coef_c = rand_coef();
    w.coef_d = rand_coef();
    // neighbouring pairs close together, as in smooth image data
    if ($urandom_range(0, 3) == 0) begin
      w.coef_c = w.coef_b + CoefW'($urandom_range(0, 64)) - 32;
      w.coef_d = w.coef_a + CoefW'($urandom_range(0, 64)) - 32;
    end
    return w;
  endfunction

  function automatic coef_word_t directed_word(input int unsigned i);
    coef_word_t w;
    case (i)
      0: w = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
      1: w = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
      2: w = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      3: w = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
      4: w = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      5: w = '{32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 32'hffff_ffff};
      6: w = '{32'hffff_fffb, 32'hffff_fff9, 32'h0000_0003, 32'h0000_0009};
      default: w = '{32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
    endcase
    return w;
  endfunction

  function automatic int rand_k();
    case ($urandom_range(0, 3))
      0: return int'($signed(16'($urandom)));
      1: return int'($urandom_range(0, 256)) - 128;
      2: return int'($urandom_range(0, 160));
      default: begin
        case ($urandom_range(0, 5))
          0:       return 32767;
          1:       return -32768;
          2:       return 0;
          3:       return -1;
          4:       return 1;
          default: return 64;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // register writes, only issued with the pipeline empty
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_INVERSE_MODE: inv_mode       = val[0];
      REG_SCALE_EVEN:   k_scale_even   = val;
      REG_SCALE_ODD:    k_scale_odd    = val;
      REG_LIFT_PREDICT: k_lift_predict = val;
      REG_LIFT_UPDATE:  k_lift_update  = val;
      REG_RECIP_EVEN:   k_recip_even   = val;
      REG_RECIP_ODD:    k_recip_odd    = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int mode, input int se, input int so, input int lp,
                          input int lu, input int re, input int ro);
    write_reg(REG_INVERSE_MODE, RegW'(mode));
    write_reg(REG_SCALE_EVEN, RegW'(se));
    write_reg(REG_SCALE_ODD, RegW'(so));
    write_reg(REG_LIFT_PREDICT, RegW'(lp));
    write_reg(REG_LIFT_UPDATE, RegW'(lu));
    write_reg(REG_RECIP_EVEN, RegW'(re));
    write_reg(REG_RECIP_ODD, RegW'(ro));
  endtask

  task automatic program_phase(input int unsigned ph);
    case (ph)
      0: ;  // reset values
      1: set_regs(0, 91, 45, 13, -22, 1, 1);
      2: set_regs(1, 64, 64, 20, -30, 45, 91);
      3: set_regs(0, 32767, 32767, 32767, 32767, 32767, 32767);
      4: set_regs(1, -32768, -32768, -32768, -32768, -32768, -32768);
      5: begin
        // mixed extremes, junk above the mode bit, then a write to no register
        set_regs(1, -32768, 32767, -32768, 32767, 0, -1);
        write_reg(REG_INVERSE_MODE, 16'hfffe);
        write_reg(REG_SPARE_IDX, 16'h1234);
      end
      default: set_regs(ph % 2, rand_k(), rand_k(), rand_k(), rand_k(), rand_k(), rand_k());
    endcase
    if (ph != 0) begin
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (words_to_send.size() != 0 || coef_bus.valid || filtered_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned n;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    coef_bus.valid    = 1'b0;
    coef_bus.coef_a   = '0;
    coef_bus.coef_b   = '0;
    coef_bus.coef_c   = '0;
    coef_bus.coef_d   = '0;
    res_bus.ready     = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_count    = 0;
    inv_mode          = 1'b0;
    k_scale_even      = 16'sd64;
    k_scale_odd       = 16'sd64;
    k_lift_predict    = 16'sd0;
    k_lift_update     = 16'sd0;
    k_recip_even      = 16'sd1;
    k_recip_odd       = 16'sd1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < NumPhases; ph++) begin
      program_phase(ph);
      // idling pattern rotates: none, sender, receiver, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph < 3) begin
        for (n = 0; n < DirectedWords; n++) begin
          words_to_send.push_back(directed_word(n));
        end
      end
      for (n = 0; n < RandomWords; n++) begin
        words_to_send.push_back(rand_word());
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // word driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    coef_word_t w;
    if (rst) begin
      coef_bus.valid <= 1'b0;
    end else if (!coef_bus.valid || coef_bus.ready) begin
      if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = words_to_send.pop_front();
        coef_bus.valid  <= 1'b1;
        coef_bus.coef_a <= w.coef_a;
        coef_bus.coef_b <= w.coef_b;
        coef_bus.coef_c <= w.coef_c;
        coef_bus.coef_d <= w.coef_d;
      end else begin
        coef_bus.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on input, compare on output
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    coef_word_t       w;
    filt_word_t       want;
    logic [CoefW-1:0] got [4];
    logic [CoefW-1:0] exp_f [4];
    string            names [4];
    names = '{"out_a", "out_b", "out_c", "out_d"};
    if (!rst) begin
      if (coef_bus.valid && coef_bus.ready) begin
        w.coef_a = coef_bus.coef_a;
        w.coef_b = coef_bus.coef_b;
        w.coef_c = coef_bus.coef_c;
        w.coef_d = coef_bus.coef_d;
        filtered_due.push_back(lapped_filter(w));
      end
      if (res_bus.valid && res_bus.ready) begin
        got = '{res_bus.out_a, res_bus.out_b, res_bus.out_c, res_bus.out_d};
        if (filtered_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h %h %h %h",
                   $realtime, got[0], got[1], got[2], got[3]);
          mismatch_count++;
        end else begin
          want  = filtered_due.pop_front();
          exp_f = '{want.out_a, want.out_b, want.out_c, want.out_d};
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== exp_f[i]) begin
              $display("%0t: %s mismatch, expected %h, actual %h",
                       $realtime, names[i], exp_f[i], got[i]);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles with no word moving
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (coef_bus.valid && coef_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[lapped_pre_post_filter_4point_unit.f]
+incdir+src
src/lppf_pkg.sv
src/lppf_coef_if.sv
src/lppf_res_if.sv
src/lapped_pre_post_filter_4point_unit.sv
dv/lapped_pre_post_filter_4point_unit_tb.sv
